// ===== design/cgg_pkg.sv =====
// Shared constants, sine table and helper function of the costmap grid fuser.
`timescale 1ns / 1ps
package cgg_pkg;

   localparam int LOCAL_DIM  = 64;
   localparam int LOCAL_HALF = LOCAL_DIM / 2;

   localparam logic [15:0]        CPM_RESET = 16'd2560;
   localparam logic signed [15:0] COS_RESET = 16'sd16384;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Quarter wave of round(16384 * sin) at 1/128-turn steps.
   localparam logic [14:0] QUARTER_SINE [0:32] = '{
      15'd0, 15'd804, 15'd1606, 15'd2404, 15'd3196, 15'd3981, 15'd4756, 15'd5520,
      15'd6270, 15'd7005, 15'd7723, 15'd8423, 15'd9102, 15'd9760, 15'd10394,
      15'd11003, 15'd11585, 15'd12140, 15'd12665, 15'd13160, 15'd13623,
      15'd14053, 15'd14449, 15'd14811, 15'd15137, 15'd15426, 15'd15679,
      15'd15893, 15'd16069, 15'd16207, 15'd16305, 15'd16364, 15'd16384
   };

   // Sine of a 1/128-turn step in Q1.14.
   function automatic logic signed [15:0] sine_step(input logic [6:0] s);
      logic [5:0]  idx;
      logic [15:0] mag;
      idx = s[5] ? (6'd32 - {1'b0, s[4:0]}) : {1'b0, s[4:0]};
      mag = {1'b0, QUARTER_SINE[idx]};
      return s[6] ? $signed(16'd0 - mag) : $signed(mag);
   endfunction

endpackage

// ===== design/cgg_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module cgg_mul
   import cgg_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [MUL_P_W-1:0] prod_ff
);

   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== design/cgg_grid_ram.sv =====
// Global grid store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module cgg_grid_ram #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data_ff
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== design/costmap_to_global_grid_fuser.sv =====
// Top level of the costmap to global grid fuser: sequencer, pose state and handshakes.
//
// After reset the block sweeps the grid RAM to zero, one cell per cycle, while
// req_tready stays low (csr writes are still taken). A pose beat or a nonzero
// cell beat steps through its states on the single shared 34 x 17 multiplier,
// which serves the five pose products and the four rotation products in turn;
// a cell that lands inside the grid also waits on the registered read of the
// grid RAM, and a zero cell beat is taken in idle and ends there. A changed
// cell leaves through a one-deep output register; the block waits only if that
// register is still full when the next delta is ready.
`timescale 1ns / 1ps
module costmap_to_global_grid_fuser
   import cgg_pkg::*;
#(
   parameter int GRID_DIM = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // yaw_angle[15:0], speed[31:16], time_step[47:32], cell_col[53:48],
   // cell_row[59:54], hazard_cost[67:60], zero fill [71:68]
   input  logic [71:0] req_tdata,
   // req_type[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // delta_index[15:0], delta_value[23:16]
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int DEPTH = GRID_DIM * GRID_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int GW    = $clog2(GRID_DIM);

   typedef enum logic [14:0] {
      ST_CLEAR = 15'b000000000000001,
      ST_IDLE  = 15'b000000000000010,
      ST_PDIST = 15'b000000000000100,
      ST_PMX   = 15'b000000000001000,
      ST_PMY   = 15'b000000000010000,
      ST_POX   = 15'b000000000100000,
      ST_POY   = 15'b000000001000000,
      ST_POYW  = 15'b000000010000000,
      ST_CM0   = 15'b000000100000000,
      ST_CM1   = 15'b000001000000000,
      ST_CM2   = 15'b000010000000000,
      ST_CM3   = 15'b000100000000000,
      ST_CSUM  = 15'b001000000000000,
      ST_CCHK  = 15'b010000000000000,
      ST_CCMP  = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0] clr_ff, clr_in;
   logic [15:0]   cpm_ff;
   logic signed [15:0] speed_ff, speed_in;
   logic [15:0]   time_ff, time_in;
   logic [5:0]    col_ff, col_in, row_ff, row_in;
   logic [7:0]    val_ff, val_in;
   logic signed [15:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [31:0] posx_ff, posx_in, posy_ff, posy_in;
   logic signed [15:0] offx_ff, offx_in, offy_ff, offy_in;
   logic signed [33:0] dist_ff, dist_in;
   logic signed [23:0] acc_ff, acc_in;
   logic signed [19:0] gx_ff, gx_in;
   logic [AW-1:0] flat_ff, flat_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [23:0]   rsp_data_ff, rsp_data_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod_ff;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data, ram_rd_data_ff;

   logic [16:0]   yaw_sum;
   logic [6:0]    step;
   logic          req_accept;
   logic signed [MUL_P_W:0] rnd18, rnd24;
   logic signed [32:0] disp;
   logic signed [34:0] pos_sum;
   logic signed [31:0] pos_sat;
   logic signed [26:0] off_wide;
   logic signed [15:0] off_sat;
   logic signed [23:0] rnd14;
   logic signed [9:0]  rot;
   logic signed [19:0] gy;
   logic signed [7:0]  lx, ly;
   logic          in_grid;
   logic          out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Heading is rounded to the nearest 1/128 turn.
   assign yaw_sum = {1'b0, req_tdata[15:0]} + 17'd256;
   assign step    = yaw_sum[15:9];

   assign lx = $signed({2'b00, col_ff}) - 8'(LOCAL_HALF);
   assign ly = $signed({2'b00, row_ff}) - 8'(LOCAL_HALF);

   // Round half away from zero as one add: a negative value loses one before the shift.
   assign rnd18 = $signed((MUL_P_W+1)'(prod_ff)) + $signed((MUL_P_W+1)'(1) << 17)
                  - $signed({{MUL_P_W{1'b0}}, prod_ff[MUL_P_W-1]});
   assign rnd24 = $signed((MUL_P_W+1)'(prod_ff)) + $signed((MUL_P_W+1)'(1) << 23)
                  - $signed({{MUL_P_W{1'b0}}, prod_ff[MUL_P_W-1]});
   assign disp     = $signed(rnd18[50:18]);
   assign off_wide = $signed(rnd24[50:24]);

   always_comb begin
      priority if (off_wide[26:15] != {12{off_wide[26]}}) begin
         off_sat = off_wide[26] ? 16'sh8000 : 16'sh7fff;
      end else begin
         off_sat = off_wide[15:0];
      end
   end

   // The position adder serves x in ST_PMY and y in ST_POX.
   always_comb begin
      pos_sum = (state_ff == ST_PMY) ? 35'(posx_ff) + 35'(disp) : 35'(posy_ff) + 35'(disp);
      priority if (pos_sum[34:31] != {4{pos_sum[34]}}) begin
         pos_sat = pos_sum[34] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         pos_sat = pos_sum[31:0];
      end
   end

   assign rnd14 = acc_ff + 24'sd8192 - $signed({23'd0, acc_ff[23]});
   assign rot   = rnd14[23:14];
   assign gy    = $signed(20'(GRID_DIM / 2)) + 20'(offy_ff) + 20'(rot);
   assign in_grid = !gx_ff[19] && (gx_ff[18:0] < 19'(GRID_DIM))
                    && !gy[19] && (gy[18:0] < 19'(GRID_DIM));

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_PDIST: begin
            mul_a = MUL_A_W'(speed_ff);
            mul_b = $signed({1'b0, time_ff});
         end
         ST_PMX: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(cos_ff);
         end
         ST_PMY: begin
            mul_a = dist_ff;
            mul_b = MUL_B_W'(sin_ff);
         end
         ST_POX: begin
            mul_a = MUL_A_W'(posx_ff);
            mul_b = $signed({1'b0, cpm_ff});
         end
         ST_POY: begin
            mul_a = MUL_A_W'(posy_ff);
            mul_b = $signed({1'b0, cpm_ff});
         end
         ST_CM0: begin
            mul_a = MUL_A_W'(lx);
            mul_b = MUL_B_W'(cos_ff);
         end
         ST_CM1: begin
            mul_a = MUL_A_W'(ly);
            mul_b = MUL_B_W'(sin_ff);
         end
         ST_CM2: begin
            mul_a = MUL_A_W'(lx);
            mul_b = MUL_B_W'(sin_ff);
         end
         ST_CM3: begin
            mul_a = MUL_A_W'(ly);
            mul_b = MUL_B_W'(cos_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      speed_in     = speed_ff;
      time_in      = time_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      val_in       = val_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      posx_in      = posx_ff;
      posy_in      = posy_ff;
      offx_in      = offx_ff;
      offy_in      = offy_ff;
      dist_in      = dist_ff;
      acc_in       = acc_ff;
      gx_in        = gx_ff;
      flat_in      = flat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = flat_ff;
      ram_wr_data  = val_ff;
      ram_rd_en    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = 8'd0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               speed_in = $signed(req_tdata[31:16]);
               time_in  = req_tdata[47:32];
               col_in   = req_tdata[53:48];
               row_in   = req_tdata[59:54];
               val_in   = req_tdata[67:60];
               if (!req_tuser) begin
                  sin_in   = sine_step(step);
                  cos_in   = sine_step(step + 7'd32);
                  state_in = ST_PDIST;
               end else if (req_tdata[67:60] != 8'd0) begin
                  state_in = ST_CM0;
               end
            end
         end
         ST_PDIST: state_in = ST_PMX;
         ST_PMX: begin
            dist_in  = prod_ff[MUL_A_W-1:0];
            state_in = ST_PMY;
         end
         ST_PMY: begin
            posx_in  = pos_sat;
            state_in = ST_POX;
         end
         ST_POX: begin
            posy_in  = pos_sat;
            state_in = ST_POY;
         end
         ST_POY: begin
            offx_in  = off_sat;
            state_in = ST_POYW;
         end
         ST_POYW: begin
            offy_in  = off_sat;
            state_in = ST_IDLE;
         end
         ST_CM0: state_in = ST_CM1;
         ST_CM1: begin
            acc_in   = prod_ff[23:0];
            state_in = ST_CM2;
         end
         ST_CM2: begin
            acc_in   = acc_ff - prod_ff[23:0];
            state_in = ST_CM3;
         end
         ST_CM3: begin
            gx_in    = $signed(20'(GRID_DIM / 2)) + 20'(offx_ff) + 20'(rot);
            acc_in   = prod_ff[23:0];
            state_in = ST_CSUM;
         end
         ST_CSUM: begin
            acc_in   = acc_ff + prod_ff[23:0];
            state_in = ST_CCHK;
         end
         ST_CCHK: begin
            flat_in = AW'(gy[GW-1:0]) * AW'(GRID_DIM) + AW'(gx_ff[GW-1:0]);
            if (in_grid) begin
               ram_rd_en = 1'b1;
               state_in  = ST_CCMP;
            end else begin
               state_in  = ST_IDLE;
            end
         end
         ST_CCMP: begin
            if (ram_rd_data_ff == val_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               ram_wr_en    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {val_ff, 16'(flat_ff)};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The read address is the same flat index that ST_CCHK registers.
   cgg_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   cgg_grid_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_grid (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_en      (ram_rd_en),
      .rd_addr    (flat_in),
      .rd_data_ff (ram_rd_data_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cpm_ff       <= CPM_RESET;
         cos_ff       <= COS_RESET;
         sin_ff       <= '0;
         posx_ff      <= '0;
         posy_ff      <= '0;
         offx_ff      <= '0;
         offy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cos_ff       <= cos_in;
         sin_ff       <= sin_in;
         posx_ff      <= posx_in;
         posy_ff      <= posy_in;
         offx_ff      <= offx_in;
         offy_ff      <= offy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            cpm_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      speed_ff    <= speed_in;
      time_ff     <= time_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      val_ff      <= val_in;
      dist_ff     <= dist_in;
      acc_ff      <= acc_in;
      gx_ff       <= gx_in;
      flat_ff     <= flat_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_reset_clears : assert property (@(posedge clock)
      reset |=> state_ff == ST_CLEAR)
      else $error("grid clearing pass did not start after reset");

   a_write_states : assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_CCMP))
      else $error("grid write outside clearing pass or cell update");

   a_delta_source : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CCMP && ram_wr_en) |=> rsp_tvalid && rsp_tdata[23:16] != 8'd0)
      else $error("cell update did not load a nonzero delta");

   a_read_in_grid : assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> (!gx_ff[19] && !gy[19]))
      else $error("grid read issued for a cell outside the grid");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the costmap to global grid fuser: directed table, then random beats.
`timescale 1ns / 1ps
module tb_top
   import cgg_pkg::*;
();

   localparam int GRID = 256;
   localparam int HALF_LOCAL = 32;
   localparam int SETTLE_CYCLES = 12;

   typedef enum logic {KIND_POSE = 1'b0, KIND_CELL = 1'b1} beat_kind_type;
   typedef enum int {CHK_NONE, CHK_TYPED, CHK_MODEL} row_check_type;

   typedef struct {
      beat_kind_type kind;
      logic [15:0]   yaw;
      logic [15:0]   spd;
      logic [15:0]   dt;
      logic [5:0]    col;
      logic [5:0]    row;
      logic [7:0]    val;
      int            reps;
      row_check_type chk;
      logic [15:0]   idx;
      logic [7:0]    dval;
   } stim_row_type;

   typedef struct {
      logic [15:0] idx;
      logic [7:0]  val;
   } grid_delta_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   costmap_to_global_grid_fuser #(.GRID_DIM(GRID)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state of the fuser.
   logic [7:0]     grid_mirror [0:GRID*GRID-1];
   logic [15:0]    cpm_now;
   int             pos_x, pos_y, cos_q14, sin_q14, off_cols, off_rows;
   grid_delta_type pending_deltas[$];
   grid_delta_type last_delta;
   int             predicted_cnt = 0;
   int             fails = 0;
   int             sender_idle_pct = 0;
   int             receiver_stall_pct = 0;

   function automatic int table_sine(int unsigned st);
      int unsigned s, r;
      int mag;
      s = st & 127;
      r = s & 31;
      mag = (s & 32) ? int'(QUARTER_SINE[32 - r]) : int'(QUARTER_SINE[r]);
      return (s & 64) ? -mag : mag;
   endfunction

   function automatic longint shift_round(longint v, int sh);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic reset_mirror();
      foreach (grid_mirror[i]) grid_mirror[i] = 8'd0;
      cpm_now = CPM_RESET;
      pos_x = 0; pos_y = 0;
      cos_q14 = 16384; sin_q14 = 0;
      off_cols = 0; off_rows = 0;
   endtask

   // Updates the mirror for one accepted beat and queues the delta it causes.
   task automatic fuse_beat(beat_kind_type kind, logic [15:0] yaw, logic [15:0] spd,
                            logic [15:0] dt, logic [5:0] col, logic [5:0] row,
                            logic [7:0] val);
      int unsigned st;
      longint travel, lx, ly, gx, gy;
      int flat;
      grid_delta_type change;
      if (kind == KIND_POSE) begin
         st = (int'(yaw) + 256) >> 9;
         sin_q14 = table_sine(st);
         cos_q14 = table_sine(st + 32);
         travel = longint'($signed(spd)) * longint'(dt);
         pos_x = int'(clip(longint'(pos_x) + shift_round(travel * cos_q14, 18),
                           -64'sd2147483648, 64'sd2147483647));
         pos_y = int'(clip(longint'(pos_y) + shift_round(travel * sin_q14, 18),
                           -64'sd2147483648, 64'sd2147483647));
         off_cols = int'(clip(shift_round(longint'(pos_x) * longint'(cpm_now), 24),
                              -32768, 32767));
         off_rows = int'(clip(shift_round(longint'(pos_y) * longint'(cpm_now), 24),
                              -32768, 32767));
      end else if (val != 8'd0) begin
         lx = longint'(col) - HALF_LOCAL;
         ly = longint'(row) - HALF_LOCAL;
         gx = GRID / 2 + off_cols + shift_round(lx * cos_q14 - ly * sin_q14, 14);
         gy = GRID / 2 + off_rows + shift_round(lx * sin_q14 + ly * cos_q14, 14);
         if (gx >= 0 && gx < GRID && gy >= 0 && gy < GRID) begin
            flat = int'(gy * GRID + gx);
            if (grid_mirror[flat] != val) begin
               grid_mirror[flat] = val;
               change.idx = flat[15:0];
               change.val = val;
               pending_deltas = {pending_deltas, change};
               last_delta = change;
               predicted_cnt++;
            end
         end
      end
   endtask

   // Drives one beat; entered and left at a falling edge.
   task automatic send_beat(beat_kind_type kind, logic [15:0] yaw, logic [15:0] spd,
                            logic [15:0] dt, logic [5:0] col, logic [5:0] row,
                            logic [7:0] val);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'd0, val, row, col, dt, spd, yaw};
      do @(posedge clock); while (!req_tready);
      fuse_beat(kind, yaw, spd, dt, col, row, val);
      @(negedge clock);
   endtask

   task automatic write_cpm(logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      cpm_now = v;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_deltas.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_random_beat();
      logic [15:0] yaw, spd, dt;
      logic [7:0] val;
      yaw = 16'($urandom);
      if ($urandom_range(99) < 15) begin
         if ($urandom_range(99) < 85) begin
            spd = 16'($urandom_range(512) - 256);
            dt = 16'($urandom_range(1024));
         end else begin
            spd = 16'($urandom);
            dt = 16'($urandom);
         end
         send_beat(KIND_POSE, yaw, spd, dt, 6'($urandom), 6'($urandom), 8'($urandom));
      end else begin
         val = ($urandom_range(99) < 10) ? 8'd0 : 8'($urandom_range(255, 1));
         send_beat(KIND_CELL, yaw, 16'($urandom), 16'($urandom), 6'($urandom),
                   6'($urandom), val);
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      grid_delta_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_deltas.size() == 0) begin
            $error("unexpected delta idx=%0d val=%0d", rsp_tdata[15:0], rsp_tdata[23:16]);
            fails++;
         end else begin
            want = pending_deltas.pop_front();
            if (rsp_tdata[15:0] !== want.idx) begin
               $error("delta_index expected %0d actual %0d", want.idx, rsp_tdata[15:0]);
               fails++;
            end
            if (rsp_tdata[23:16] !== want.val) begin
               $error("delta_value expected %0d actual %0d", want.val, rsp_tdata[23:16]);
               fails++;
            end
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= !(receiver_stall_pct > 0 && $urandom_range(99) < receiver_stall_pct);

   initial begin
      // The grid clear after reset alone sweeps all 65536 cells.
      #5ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      stim_row_type rows [$];
      logic [15:0] cpm_plan [6];
      int before_cnt;
      reset_mirror();
      rows = '{
         '{KIND_CELL, 0, 0, 0, 32, 32, 5, 1, CHK_TYPED, 16'd32896, 8'd5},
         '{KIND_CELL, 0, 0, 0, 0, 0, 255, 1, CHK_TYPED, 16'd24672, 8'd255},
         '{KIND_CELL, 0, 0, 0, 63, 63, 1, 1, CHK_TYPED, 16'd40863, 8'd1},
         // Same value again leaves the cell unchanged.
         '{KIND_CELL, 0, 0, 0, 63, 63, 1, 1, CHK_NONE, 0, 0},
         '{KIND_CELL, 0, 0, 0, 10, 20, 0, 1, CHK_NONE, 0, 0},
         '{KIND_POSE, 0, 0, 0, 0, 0, 0, 1, CHK_NONE, 0, 0},
         '{KIND_POSE, 16384, 256, 4096, 0, 0, 0, 1, CHK_NONE, 0, 0},
         '{KIND_CELL, 0, 0, 0, 32, 32, 7, 1, CHK_MODEL, 0, 0},
         '{KIND_POSE, 65535, 16'h8000, 65535, 63, 63, 255, 1, CHK_NONE, 0, 0},
         '{KIND_POSE, 255, 100, 100, 0, 0, 0, 1, CHK_NONE, 0, 0},
         '{KIND_POSE, 256, 16'hFF9C, 100, 0, 0, 0, 1, CHK_NONE, 0, 0},
         '{KIND_CELL, 0, 0, 0, 0, 63, 200, 1, CHK_MODEL, 0, 0},
         // Drive the position into negative then positive saturation.
         '{KIND_POSE, 32768, 32767, 65535, 0, 0, 0, 17, CHK_NONE, 0, 0},
         '{KIND_CELL, 0, 0, 0, 5, 5, 9, 1, CHK_NONE, 0, 0},
         '{KIND_POSE, 0, 32767, 65535, 0, 0, 0, 34, CHK_NONE, 0, 0},
         '{KIND_CELL, 0, 0, 0, 40, 8, 9, 1, CHK_NONE, 0, 0},
         '{KIND_POSE, 32768, 32767, 65535, 0, 0, 0, 16, CHK_NONE, 0, 0},
         '{KIND_POSE, 49152, 256, 2048, 0, 0, 0, 1, CHK_NONE, 0, 0},
         '{KIND_CELL, 0, 0, 0, 63, 0, 128, 1, CHK_MODEL, 0, 0},
         '{KIND_CELL, 0, 0, 0, 31, 33, 77, 1, CHK_MODEL, 0, 0}
      };
      cpm_plan = '{16'd0, 16'd65535, 16'd1, CPM_RESET, 16'($urandom), 16'($urandom)};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[r]) begin
         for (int k = 0; k < rows[r].reps; k++) begin
            before_cnt = predicted_cnt;
            send_beat(rows[r].kind, rows[r].yaw, rows[r].spd, rows[r].dt,
                      rows[r].col, rows[r].row, rows[r].val);
            if (rows[r].chk == CHK_TYPED &&
                (predicted_cnt != before_cnt + 1 ||
                 last_delta.idx !== rows[r].idx ||
                 last_delta.val !== rows[r].dval)) begin
               $error("row %0d delta_index expected %0d actual %0d, delta_value expected %0d actual %0d",
                      r, rows[r].idx, last_delta.idx, rows[r].dval, last_delta.val);
               fails++;
            end
            if (rows[r].chk == CHK_NONE && predicted_cnt != before_cnt) begin
               $error("row %0d delta count expected 0 actual %0d", r,
                      predicted_cnt - before_cnt);
               fails++;
            end
         end
      end

      // Random phases; each starts idle with a fresh scale and its own idling.
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_cpm(cpm_plan[ph]);
         sender_idle_pct = (ph % 4 == 1) ? 86 : ((ph % 4 == 3) ? 33 : 0);
         receiver_stall_pct = (ph % 4 == 2) ? 86 : ((ph % 4 == 3) ? 33 : 0);
         // A short, slow pose opens each phase so the new scale takes effect.
         send_beat(KIND_POSE, 16'($urandom), 16'($urandom_range(512) - 256),
                   16'($urandom_range(64)), 6'd0, 6'd0, 8'd0);
         for (int n = 0; n < 150; n++) send_random_beat();
      end

      drain();
      if (fails == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
